// File: rtl/bic_pkg.sv
// Shared constants, opcodes and types for the Brainfuck interpreter core.
package bic_pkg;

   localparam int PROG_DEPTH_DEF = 1024;
   localparam int TAPE_DEPTH_DEF = 4096;
   localparam int NEST_DEPTH_DEF = 64;
   localparam int IN_DEPTH_DEF   = 64;

   localparam logic [7:0] EOF_RESET = 8'hFF;

   typedef enum logic [2:0] {
      OP_RIGHT = 3'd0,
      OP_LEFT  = 3'd1,
      OP_INC   = 3'd2,
      OP_DEC   = 3'd3,
      OP_OUT   = 3'd4,
      OP_IN    = 3'd5,
      OP_OPEN  = 3'd6,
      OP_CLOSE = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      REQ_LOAD = 2'd0,
      REQ_PUSH = 2'd1,
      REQ_STEP = 2'd2,
      REQ_NONE = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_PROG_FUL = 2'd1,
      ST_BRACKET  = 2'd2,
      ST_IN_FULL  = 2'd3
   } status_type;

   // Maps a character to an opcode; valid clear for non-command characters.
   typedef struct packed {
      logic       valid;
      opcode_type op;
   } decode_type;

   function automatic decode_type decode_char(input logic [7:0] ch);
      decode_type d;
      d.valid = 1'b1;
      d.op    = OP_RIGHT;
      case (ch)
         8'h3E: d.op = OP_RIGHT;
         8'h3C: d.op = OP_LEFT;
         8'h2B: d.op = OP_INC;
         8'h2D: d.op = OP_DEC;
         8'h2E: d.op = OP_OUT;
         8'h2C: d.op = OP_IN;
         8'h5B: d.op = OP_OPEN;
         8'h5D: d.op = OP_CLOSE;
         default: d.valid = 1'b0;
      endcase
      return d;
   endfunction

endpackage

// File: rtl/bic_tape.sv
// Tape memory: registered read, write port, clearing sweep after reset.
module bic_tape #(
   parameter int TAPE_DEPTH = bic_pkg::TAPE_DEPTH_DEF,
   localparam int TW = $clog2(TAPE_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [TW-1:0] rd_addr,
   output logic [7:0]    rd_data,
   input  logic          wr_en,
   input  logic [TW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   output logic          clear_busy
);
   logic [7:0]    mem [TAPE_DEPTH];
   logic [TW-1:0] clr_ptr_ff, clr_ptr_in;
   logic          busy_ff, busy_in;

   always_comb begin
      clr_ptr_in = clr_ptr_ff;
      busy_in    = busy_ff;
      if (busy_ff) begin
         clr_ptr_in = clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == TW'(TAPE_DEPTH - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
         busy_ff    <= 1'b1;
      end else begin
         clr_ptr_ff <= clr_ptr_in;
         busy_ff    <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ptr_ff] <= 8'd0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

   assign clear_busy = busy_ff;
endmodule

// File: rtl/bic_prog.sv
// Program store and jump table memories with registered reads.
module bic_prog #(
   parameter int PROG_DEPTH = bic_pkg::PROG_DEPTH_DEF,
   localparam int PW = $clog2(PROG_DEPTH)
) (
   input  logic                clock,
   input  logic [PW-1:0]       rd_addr,
   output bic_pkg::opcode_type rd_op,
   output logic [PW-1:0]       rd_jump,
   input  logic                op_wr,
   input  logic [PW-1:0]       op_addr,
   input  bic_pkg::opcode_type op_data,
   input  logic                jt_wr,
   input  logic [PW-1:0]       jt_addr,
   input  logic [PW-1:0]       jt_data
);
   bic_pkg::opcode_type prog_mem [PROG_DEPTH];
   logic [PW-1:0]       jump_mem [PROG_DEPTH];

   always_ff @(posedge clock) begin
      if (op_wr) prog_mem[op_addr] <= op_data;
      rd_op <= prog_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (jt_wr) jump_mem[jt_addr] <= jt_data;
      rd_jump <= jump_mem[rd_addr];
   end
endmodule

// File: rtl/brainfuck_interpreter_core.sv
// Top level of the Brainfuck interpreter core: loader, input FIFO and step engine.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------------
//  req_     | in  | tvalid / tready    | tuser[1:0] req_type, tdata[7:0] payload_byte
//  rsp_     | out | tvalid / tready    | tdata[0] out_valid, [8:1] out_byte,
//           |     |                    |   [9] halted, [11:10] status
//  csr_     | in  | valid / ready      | wdata[7:0] eof_value
//
// Load and push beats pass through accept, result register loaded, rsp_ beat.
// A step that runs passes through accept (program, jump and tape reads issued),
// execute with the cell write-back, result register loaded, rsp_ beat; a step
// that is halted or meets open brackets skips execute. A ']' load that pairs
// writes the forward jump entry in one state, the back pointer in the next.
// After reset a clearing sweep zeroes the tape; no request beat is taken
// during it. A waiting result holds the engine until the rsp_ beat completes.
module brainfuck_interpreter_core #(
   parameter int PROG_DEPTH = bic_pkg::PROG_DEPTH_DEF,
   parameter int TAPE_DEPTH = bic_pkg::TAPE_DEPTH_DEF,
   parameter int NEST_DEPTH = bic_pkg::NEST_DEPTH_DEF,
   parameter int IN_DEPTH   = bic_pkg::IN_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] payload_byte
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] out_valid, [8:1] out_byte, [9] halted,
                                    // [11:10] status, [15:12] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata    // [7:0] eof_value
);
   localparam int PW = $clog2(PROG_DEPTH);
   localparam int LW = $clog2(PROG_DEPTH + 1);
   localparam int TW = $clog2(TAPE_DEPTH);
   localparam int NW = $clog2(NEST_DEPTH);
   localparam int DW = $clog2(NEST_DEPTH + 1);
   localparam int IW = $clog2(IN_DEPTH);
   localparam int CW = $clog2(IN_DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_CLOSE = 5'b00100,
      S_DONE  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]  eof_ff;
   logic [LW-1:0] plen_ff, plen_in;
   logic [LW-1:0] pc_ff, pc_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [TW-1:0] tp_ff, tp_in;
   logic [CW-1:0] icnt_ff, icnt_in;
   logic [IW-1:0] ihead_ff, ihead_in;
   logic          stepping_ff, stepping_in;
   logic [11:0]   rsp_ff, rsp_in;

   // Bracket stack and input FIFO memories (registered reads).
   logic [PW-1:0] stack_mem [NEST_DEPTH];
   logic [7:0]    fifo_mem  [IN_DEPTH];
   logic [PW-1:0] stack_rd;
   logic [7:0]    fifo_rd;
   logic          stack_wr;
   logic [NW-1:0] stack_wa, stack_ra;
   logic          fifo_wr;
   logic [IW-1:0] fifo_wa;
   logic [IW:0]   fifo_sum;

   // Program memories
   bic_pkg::opcode_type rd_op;
   bic_pkg::opcode_type op_data;
   logic [PW-1:0]       rd_jump;
   logic                op_wr, jt_wr;
   logic [PW-1:0]       jt_addr, jt_data;

   // Tape
   logic [7:0] cell_rd;
   logic       tape_wr;
   logic [7:0] tape_wd;
   logic       clear_busy;

   logic              accept;
   bic_pkg::decode_type dec;
   logic [PW-1:0]     pos;
   bic_pkg::req_kind_type kind;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !clear_busy;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {4'd0, rsp_ff};
   assign kind       = bic_pkg::req_kind_type'(req_tuser);
   assign dec        = bic_pkg::decode_char(req_tdata);
   assign pos        = plen_ff[PW-1:0];
   assign stack_ra   = NW'(depth_ff - 1'b1);
   // FIFO tail = head + count, wrapped at IN_DEPTH
   assign fifo_sum   = {1'b0, ihead_ff} + {1'b0, icnt_ff[IW-1:0]};

   always_ff @(posedge clock) begin
      if (stack_wr) stack_mem[stack_wa] <= pos;
      stack_rd <= stack_mem[stack_ra];
      if (fifo_wr) fifo_mem[fifo_wa] <= req_tdata;
      fifo_rd <= fifo_mem[ihead_ff];
   end

   bic_prog #(.PROG_DEPTH(PROG_DEPTH)) u_prog (
      .clock   (clock),
      .rd_addr (pc_ff[PW-1:0]),
      .rd_op   (rd_op),
      .rd_jump (rd_jump),
      .op_wr   (op_wr),
      .op_addr (pos),
      .op_data (op_data),
      .jt_wr   (jt_wr),
      .jt_addr (jt_addr),
      .jt_data (jt_data)
   );

   bic_tape #(.TAPE_DEPTH(TAPE_DEPTH)) u_tape (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (tp_ff),
      .rd_data    (cell_rd),
      .wr_en      (tape_wr),
      .wr_addr    (tp_ff),
      .wr_data    (tape_wd),
      .clear_busy (clear_busy)
   );

   always_comb begin
      state_in    = state_ff;
      plen_in     = plen_ff;
      pc_in       = pc_ff;
      depth_in    = depth_ff;
      tp_in       = tp_ff;
      icnt_in     = icnt_ff;
      ihead_in    = ihead_ff;
      stepping_in = stepping_ff;
      rsp_in      = rsp_ff;
      stack_wr    = 1'b0;
      stack_wa    = depth_ff[NW-1:0];
      fifo_wr     = 1'b0;
      fifo_wa     = (fifo_sum >= (IW+1)'(IN_DEPTH)) ?
                    IW'(fifo_sum - (IW+1)'(IN_DEPTH)) : fifo_sum[IW-1:0];
      op_wr       = 1'b0;
      op_data     = dec.op;
      jt_wr       = 1'b0;
      jt_addr     = pos;
      jt_data     = stack_rd;
      tape_wr     = 1'b0;
      tape_wd     = cell_rd;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in = {bic_pkg::ST_OK, 10'd0};
               state_in = S_DONE;
               case (kind)
                  bic_pkg::REQ_LOAD: begin
                     if (!dec.valid) begin
                        // dropped character
                     end else if (plen_ff >= LW'(PROG_DEPTH)) begin
                        rsp_in[11:10] = bic_pkg::ST_PROG_FUL;
                     end else if (dec.op == bic_pkg::OP_OPEN) begin
                        if (depth_ff >= DW'(NEST_DEPTH)) begin
                           rsp_in[11:10] = bic_pkg::ST_BRACKET;
                        end else begin
                           stack_wr = 1'b1;
                           depth_in = depth_ff + 1'b1;
                           op_wr    = 1'b1;
                           plen_in  = plen_ff + 1'b1;
                        end
                     end else if (dec.op == bic_pkg::OP_CLOSE) begin
                        if (depth_ff == '0) begin
                           rsp_in[11:10] = bic_pkg::ST_BRACKET;
                        end else begin
                           // stack top read lands next cycle
                           state_in = S_CLOSE;
                        end
                     end else begin
                        op_wr   = 1'b1;
                        plen_in = plen_ff + 1'b1;
                     end
                  end
                  bic_pkg::REQ_PUSH: begin
                     if (icnt_ff >= CW'(IN_DEPTH)) begin
                        rsp_in[11:10] = bic_pkg::ST_IN_FULL;
                     end else begin
                        fifo_wr = 1'b1;
                        icnt_in = icnt_ff + 1'b1;
                     end
                  end
                  bic_pkg::REQ_STEP: begin
                     if (pc_ff >= plen_ff) begin
                        // halted: nothing runs
                     end else if (depth_ff != '0) begin
                        rsp_in[11:10] = bic_pkg::ST_BRACKET;
                     end else begin
                        state_in = S_EXEC;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CLOSE: begin
            // pair ']' at pos with the '[' on top of the stack
            jt_wr    = 1'b1;
            jt_addr  = stack_rd;
            jt_data  = pos;
            stepping_in = 1'b1;
            depth_in = depth_ff - 1'b1;
            state_in = S_DONE;
         end
         S_EXEC: begin
            state_in = S_DONE;
            pc_in    = pc_ff + 1'b1;
            case (rd_op)
               bic_pkg::OP_RIGHT: begin
                  tp_in = (tp_ff == TW'(TAPE_DEPTH - 1)) ? '0 : tp_ff + 1'b1;
               end
               bic_pkg::OP_LEFT: begin
                  tp_in = (tp_ff == '0) ? TW'(TAPE_DEPTH - 1) : tp_ff - 1'b1;
               end
               bic_pkg::OP_INC: begin
                  tape_wr = 1'b1;
                  tape_wd = cell_rd + 8'd1;
               end
               bic_pkg::OP_DEC: begin
                  tape_wr = 1'b1;
                  tape_wd = cell_rd - 8'd1;
               end
               bic_pkg::OP_OUT: begin
                  rsp_in[0]   = 1'b1;
                  rsp_in[8:1] = cell_rd;
               end
               bic_pkg::OP_IN: begin
                  tape_wr = 1'b1;
                  if (icnt_ff != '0) begin
                     tape_wd  = fifo_rd;
                     ihead_in = (ihead_ff == IW'(IN_DEPTH - 1)) ? '0 : ihead_ff + 1'b1;
                     icnt_in  = icnt_ff - 1'b1;
                  end else begin
                     tape_wd = eof_ff;
                  end
               end
               bic_pkg::OP_OPEN: begin
                  if (cell_rd == 8'd0) pc_in = LW'(rd_jump) + 1'b1;
               end
               default: begin
                  if (cell_rd != 8'd0) pc_in = LW'(rd_jump);
               end
            endcase
         end
         S_DONE: begin
            if (stepping_ff) begin
               // second half of ']' load: back pointer and the opcode
               jt_wr       = 1'b1;
               jt_addr     = pos;
               jt_data     = stack_rd;
               op_wr       = 1'b1;
               op_data     = bic_pkg::OP_CLOSE;
               plen_in     = plen_ff + 1'b1;
               stepping_in = 1'b0;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_in[9] = (pc_ff >= plen_ff);
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // halted flag settles once pc and length are final
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         eof_ff      <= bic_pkg::EOF_RESET;
         plen_ff     <= '0;
         pc_ff       <= '0;
         depth_ff    <= '0;
         tp_ff       <= '0;
         icnt_ff     <= '0;
         ihead_ff    <= '0;
         stepping_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         plen_ff     <= plen_in;
         pc_ff       <= pc_in;
         depth_ff    <= depth_in;
         tp_ff       <= tp_in;
         icnt_ff     <= icnt_in;
         ihead_ff    <= ihead_in;
         stepping_ff <= stepping_in;
         if (csr_valid && csr_ready) eof_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE) rsp_ff <= {rsp_in[11:10], (pc_ff >= plen_in), rsp_in[8:0]};
      else if (state_ff != S_RESP) rsp_ff <= rsp_in;
   end

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_tready) else $error("request taken during tape clear");
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      icnt_ff <= CW'(IN_DEPTH)) else $error("input count overflow");
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(NEST_DEPTH)) else $error("bracket depth overflow");
   a_pc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> (pc_ff < plen_ff)) else $error("step past end");
endmodule
